>>> src/plc_pkg.sv
package plc_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (OCC_W > 6) ? OCC_W : 6;

  // operation kinds on the input channel
  localparam logic [2:0] K_INS_FRONT = 3'd0;
  localparam logic [2:0] K_INS_END   = 3'd1;
  localparam logic [2:0] K_INS_POS   = 3'd2;
  localparam logic [2:0] K_DEL_FRONT = 3'd3;
  localparam logic [2:0] K_DEL_END   = 3'd4;
  localparam logic [2:0] K_DEL_POS   = 3'd5;
  localparam logic [2:0] K_READ      = 3'd6;
  localparam logic [2:0] K_DUMP      = 3'd7;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // decoded operation class
  localparam logic [1:0] CLS_INS  = 2'd0;
  localparam logic [1:0] CLS_DEL  = 2'd1;
  localparam logic [1:0] CLS_READ = 2'd2;
  localparam logic [1:0] CLS_DUMP = 2'd3;

  // where in the list the operation acts
  localparam logic [1:0] WH_FRONT = 2'd0;
  localparam logic [1:0] WH_END   = 2'd1;
  localparam logic [1:0] WH_POS   = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [4:0]         index_out;
    logic [5:0]         entries;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         cls;
    logic [1:0]         where;
    logic [5:0]         position;
    logic signed [31:0] value;
  } op_t;

endpackage

>>> src/plc_front.sv
module plc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  plc_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output plc_pkg::op_t      q_op
);
  import plc_pkg::*;

  op_t        dec;
  op_t        q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // classify the kind into class and place
  always_comb begin
    dec.position = in_item.position;
    dec.value    = in_item.value;
    dec.cls      = CLS_INS;
    dec.where    = WH_FRONT;
    case (in_item.kind)
      K_INS_FRONT: begin dec.cls = CLS_INS;  dec.where = WH_FRONT; end
      K_INS_END:   begin dec.cls = CLS_INS;  dec.where = WH_END;   end
      K_INS_POS:   begin dec.cls = CLS_INS;  dec.where = WH_POS;   end
      K_DEL_FRONT: begin dec.cls = CLS_DEL;  dec.where = WH_FRONT; end
      K_DEL_END:   begin dec.cls = CLS_DEL;  dec.where = WH_END;   end
      K_DEL_POS:   begin dec.cls = CLS_DEL;  dec.where = WH_POS;   end
      K_READ:      begin dec.cls = CLS_READ; dec.where = WH_POS;   end
      K_DUMP:      begin dec.cls = CLS_DUMP; dec.where = WH_FRONT; end
      default:     begin dec.cls = CLS_INS;  dec.where = WH_FRONT; end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> (cnt_r == 2'd2))
    else $error("full queue lost an entry");

endmodule

>>> src/plc_back.sv
module plc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  plc_pkg::op_t       q_op,
  output logic               out_valid,
  input  logic               out_ready,
  output plc_pkg::out_item_t out_item
);
  import plc_pkg::*;

  logic [31:0]      slots_r [CAPACITY];
  logic [31:0]      slots_nxt [CAPACITY];
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             dumping_r, dumping_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [OCC_W-1:0] target;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_val;
  logic [CMP_W-1:0] occ_x, pos_x, tgt_x, cnt_x, occn_x;
  logic [1:0]       status;
  logic             can_emit, dump_last, ok;

  assign occ_x = CMP_W'(occ_r);
  assign pos_x = CMP_W'(q_op.position);
  assign tgt_x = CMP_W'(target);
  assign cnt_x = CMP_W'(cnt_r);

  always_comb begin
    case (q_op.where)
      WH_FRONT: target = '0;
      WH_END:   target = (q_op.cls == CLS_INS) ? occ_r : occ_r - OCC_W'(1);
      WH_POS:   target = OCC_W'(q_op.position);
      default:  target = '0;
    endcase
  end

  // one read port, shared by dump walk and delete/read
  assign rd_idx = dumping_r ? cnt_r : target[IDX_W-1:0];
  assign rd_val = slots_r[rd_idx];
  assign dump_last = (cnt_x + CMP_W'(1) == occ_x);

  always_comb begin
    case (q_op.cls)
      CLS_INS: begin
        if (q_op.where == WH_POS && pos_x > occ_x) status = ST_BADPOS;
        else if (occ_x >= CMP_W'(CAPACITY))        status = ST_FULL;
        else                                       status = ST_OK;
      end
      CLS_DEL, CLS_READ: begin
        if (occ_r == '0)                                 status = ST_EMPTY;
        else if (q_op.where == WH_POS && pos_x >= occ_x) status = ST_BADPOS;
        else                                             status = ST_OK;
      end
      CLS_DUMP: status = (occ_r == '0) ? ST_EMPTY : ST_OK;
      default:  status = ST_OK;
    endcase
  end
  assign ok = (status == ST_OK);

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    occ_nxt       = occ_r;
    occn_x        = CMP_W'(occ_r);
    dumping_nxt   = dumping_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    for (int i = 0; i < CAPACITY; i++) slots_nxt[i] = slots_r[i];

    if (can_emit) begin
      if (dumping_r) begin
        out_nxt.status    = ST_OK;
        out_nxt.data_out  = rd_val;
        out_nxt.index_out = cnt_x[4:0];
        out_nxt.entries   = occ_x[5:0];
        out_nxt.last      = dump_last;
        out_valid_nxt     = 1'b1;
        cnt_nxt           = cnt_r + IDX_W'(1);
        if (dump_last) dumping_nxt = 1'b0;
      end else if (q_valid) begin
        q_pop = 1'b1;
        if (q_op.cls == CLS_DUMP && ok) begin
          dumping_nxt = 1'b1;
          cnt_nxt     = '0;
        end else begin
          if (ok && q_op.cls == CLS_INS) begin
            occ_nxt = occ_r + OCC_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (OCC_W'(i) == target)    slots_nxt[i] = q_op.value;
              else if (OCC_W'(i) > target) slots_nxt[i] = slots_r[(i == 0) ? 0 : i - 1];
            end
          end else if (ok && q_op.cls == CLS_DEL) begin
            occ_nxt = occ_r - OCC_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (OCC_W'(i) >= target) slots_nxt[i] = slots_r[i + 1];
            end
          end
          occn_x            = CMP_W'(occ_nxt);
          out_nxt.status    = status;
          out_nxt.data_out  = (ok && (q_op.cls == CLS_DEL || q_op.cls == CLS_READ))
                              ? rd_val : '0;
          out_nxt.index_out = (ok && (q_op.cls == CLS_DEL || q_op.cls == CLS_READ))
                              ? tgt_x[4:0] : 5'd0;
          out_nxt.entries   = occn_x[5:0];
          out_nxt.last      = 1'b1;
          out_valid_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      dumping_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      dumping_r   <= dumping_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < CAPACITY; i++) slots_r[i] <= slots_nxt[i];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_x <= CMP_W'(CAPACITY)) else $error("occupancy above capacity");
  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> (cnt_x < occ_x)) else $error("dump index past end");
  a_no_pop_dump: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> !q_pop) else $error("item taken during dump");
  a_occ_still_dump: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |=> $stable(occ_r)) else $error("list changed during dump");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result dropped or changed");

endmodule

>>> src/positional_circular_list.sv
// Ordered list of up to CAPACITY (32) signed 32-bit values, front at index 0.
// Each input transfer is one operation: insert at front, end or position;
// delete at front, end or position (the removed value comes back); read at a
// position; or dump, which gives one result transfer per stored entry, front
// first, with last set on the final one (an empty list dumps a single result
// with status "empty"). Every other operation gives exactly one result, last
// set. Errors leave the list unchanged and return zero data and index.
// Timing: a two-entry queue takes input transfers while the executing side
// works; insert, delete and read never hold the executing side, so one
// operation per cycle is sustained while results are taken. A dump starts
// the walk, then reads one entry per result through the single slot read
// port and takes no new operation until the walk ends. All slots shift in
// parallel, so position has no effect on latency. There is no start-up pass.
module positional_circular_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output plc_pkg::out_item_t out_item
);
  import plc_pkg::*;

  // decoded operations between the accepting front and the executing back
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  // front: classify the kind, buffer up to two operations
  plc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op)
  );

  // back: slot array, occupancy, dump walker and registered result stage
  plc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
